@@ hdl/clw_pkg.sv @@
// Shared types and constants for the character LCD text writer.
// No dependencies.
package clw_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] LCD_CMD_CLEAR = 8'h01;
    localparam logic       LCD_DDRAM_BIT = 1'b1;
    localparam logic       RS_CMD        = 1'b0;
    localparam logic       RS_DATA       = 1'b1;
    localparam logic [2:0] LAST_ROW      = 3'd3;

    typedef enum logic [2:0] {
        CMD_CHAR    = 3'd0,
        CMD_NEWLINE = 3'd1,
        CMD_SET     = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_RAW     = 3'd4
    } cmd_e;

    typedef enum logic [2:0] {
        CFG_COLUMNS   = 3'd0,
        CFG_ROWS      = 3'd1,
        CFG_ROW0_BASE = 3'd2,
        CFG_ROW1_BASE = 3'd3,
        CFG_ROW2_BASE = 3'd4,
        CFG_ROW3_BASE = 3'd5
    } cfg_idx_e;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE_HI,
        BK_PRE_LO,
        BK_MAIN_HI,
        BK_MAIN_LO
    } bk_state_e;

    typedef struct packed {
        logic [5:0]      columns;
        logic [2:0]      rows;
        logic [3:0][6:0] row_base;
    } cfg_t;

    // One request as bus bytes: optional address move, then the main byte.
    typedef struct packed {
        logic       has_pre;
        logic [7:0] pre_byte;
        logic [7:0] main_byte;
        logic       main_rs;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ hdl/char_lcd_text_writer.sv @@
// Character LCD text writer top level: config registers, front end, queue, serializer.
// Depends on clw_pkg, clw_front, clw_fifo, clw_back.
//
// Turns text requests into 4-bit bus nibbles (high nibble first) for an
// HD44780-style display. A request is taken whenever the two-entry job
// queue has room, so requests may arrive back to back. The serializer sends
// one nibble per cycle through an output register while m_ready is high: a
// request is two nibbles on the bus (four for a character that wraps to the
// next row), and that serializer sets the sustained rate. Unknown commands are
// accepted and produce nothing. Registers are written through cfg_wr_en/cfg_index/
// cfg_data; the user must do so only while no request is in flight (not enforced).
module char_lcd_text_writer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_value,
    input  logic [6:0] s_column,
    input  logic [1:0] s_row,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_nibble,
    output logic       m_register_select,
    output logic       m_last
);
    import clw_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    job_t      push_job;
    job_t      head_job;
    logic      push;
    logic      pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_e'(cfg_index))
                CFG_COLUMNS:   cfg_next.columns     = cfg_data[5:0];
                CFG_ROWS:      cfg_next.rows        = cfg_data[2:0];
                CFG_ROW0_BASE: cfg_next.row_base[0] = cfg_data;
                CFG_ROW1_BASE: cfg_next.row_base[1] = cfg_data;
                CFG_ROW2_BASE: cfg_next.row_base[2] = cfg_data;
                CFG_ROW3_BASE: cfg_next.row_base[3] = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns     <= 6'd20;
            cfg_reg.rows        <= 3'd4;
            cfg_reg.row_base[0] <= 7'd0;
            cfg_reg.row_base[1] <= 7'd64;
            cfg_reg.row_base[2] <= 7'd20;
            cfg_reg.row_base[3] <= 7'd84;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    clw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .s_column  (s_column),
        .s_row     (s_row),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    clw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    clw_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_status          (q_status),
        .head_job          (head_job),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_nibble          (m_nibble),
        .m_register_select (m_register_select),
        .m_last            (m_last)
    );

    a_q_status_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("job pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("job popped from an empty queue");

    a_unknown_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command > CMD_RAW) |-> !push)
        else $error("unknown command produced a job");

endmodule

@@ hdl/clw_front.sv @@
// Request front end: accepts requests, tracks the cursor, builds byte jobs.
// Depends on clw_pkg.
module clw_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  clw_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [7:0]        s_value,
    input  logic [6:0]        s_column,
    input  logic [1:0]        s_row,
    input  clw_pkg::q_status_t q_status,
    output logic              push,
    output clw_pkg::job_t     push_job
);
    import clw_pkg::*;

    logic [6:0] cur_col_reg, cur_col_next;
    logic [1:0] cur_row_reg, cur_row_next;
    logic [2:0] row_inc;
    logic [1:0] nl_row;
    logic [6:0] nl_addr;
    logic [6:0] set_addr;
    logic       wrap;
    logic       accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_inc = {1'b0, cur_row_reg} + 3'd1;
        if (row_inc >= cfg.rows || row_inc > LAST_ROW) begin
            nl_row = 2'd0;
        end else begin
            nl_row = row_inc[1:0];
        end
    end

    assign nl_addr  = cfg.row_base[nl_row];
    assign set_addr = cfg.row_base[s_row] + s_column;
    assign wrap     = cur_col_reg >= {1'b0, cfg.columns};

    always_comb begin
        push_job     = '0;
        push         = 1'b0;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (cmd_e'(s_command))
            CMD_CHAR: begin
                push               = accept;
                push_job.has_pre   = wrap;
                push_job.pre_byte  = {LCD_DDRAM_BIT, nl_addr};
                push_job.main_byte = s_value;
                push_job.main_rs   = RS_DATA;
                if (accept) begin
                    if (wrap) begin
                        cur_col_next = 7'd1;
                        cur_row_next = nl_row;
                    end else begin
                        cur_col_next = cur_col_reg + 7'd1;
                    end
                end
            end
            CMD_NEWLINE: begin
                push               = accept;
                push_job.main_byte = {LCD_DDRAM_BIT, nl_addr};
                push_job.main_rs   = RS_CMD;
                if (accept) begin
                    cur_col_next = 7'd0;
                    cur_row_next = nl_row;
                end
            end
            CMD_SET: begin
                push               = accept;
                push_job.main_byte = {LCD_DDRAM_BIT, set_addr};
                push_job.main_rs   = RS_CMD;
                if (accept) begin
                    cur_col_next = s_column;
                    cur_row_next = s_row;
                end
            end
            CMD_CLEAR: begin
                push               = accept;
                push_job.main_byte = LCD_CMD_CLEAR;
                push_job.main_rs   = RS_CMD;
                if (accept) begin
                    cur_col_next = 7'd0;
                    cur_row_next = 2'd0;
                end
            end
            CMD_RAW: begin
                push               = accept;
                push_job.main_byte = s_value;
                push_job.main_rs   = RS_CMD;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

endmodule

@@ hdl/clw_fifo.sv @@
// Short job queue between the front end and the nibble serializer.
// Depends on clw_pkg.
module clw_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  clw_pkg::job_t      push_job,
    input  logic               pop,
    output clw_pkg::job_t      head_job,
    output clw_pkg::q_status_t status
);
    import clw_pkg::*;

    job_t              mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = count_reg == (Q_AW+1)'(Q_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/clw_back.sv @@
// Nibble serializer: splits queued byte jobs into high/low nibbles.
// Depends on clw_pkg.
module clw_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  clw_pkg::q_status_t q_status,
    input  clw_pkg::job_t      head_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_nibble,
    output logic               m_register_select,
    output logic               m_last
);
    import clw_pkg::*;

    bk_state_e  state_reg, state_next;
    job_t       job_reg, job_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_nibble_reg, out_nibble_next;
    logic       out_rs_reg, out_rs_next;
    logic       out_last_reg, out_last_next;
    logic       load_out;
    logic       advance;
    logic [3:0] nib;
    logic       nib_rs;
    logic       nib_last;

    assign load_out = !out_valid_reg || m_ready;
    assign advance  = (state_reg != BK_IDLE) && load_out;
    assign pop      = !q_status.empty
                      && (state_reg == BK_IDLE || (advance && state_reg == BK_MAIN_LO));

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        if (pop) begin
            job_next   = head_job;
            state_next = head_job.has_pre ? BK_PRE_HI : BK_MAIN_HI;
        end else if (advance) begin
            case (state_reg)
                BK_PRE_HI:  state_next = BK_PRE_LO;
                BK_PRE_LO:  state_next = BK_MAIN_HI;
                BK_MAIN_HI: state_next = BK_MAIN_LO;
                BK_MAIN_LO: state_next = BK_IDLE;
                default:    state_next = BK_IDLE;
            endcase
        end
    end

    always_comb begin
        nib      = '0;
        nib_rs   = RS_CMD;
        nib_last = 1'b0;
        case (state_reg)
            BK_PRE_HI:  nib = job_reg.pre_byte[7:4];
            BK_PRE_LO:  nib = job_reg.pre_byte[3:0];
            BK_MAIN_HI: begin
                nib    = job_reg.main_byte[7:4];
                nib_rs = job_reg.main_rs;
            end
            BK_MAIN_LO: begin
                nib      = job_reg.main_byte[3:0];
                nib_rs   = job_reg.main_rs;
                nib_last = 1'b1;
            end
            default: nib = '0;
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_nibble_next = out_nibble_reg;
        out_rs_next     = out_rs_reg;
        out_last_next   = out_last_reg;
        if (load_out) begin
            out_valid_next  = advance;
            out_nibble_next = nib;
            out_rs_next     = nib_rs;
            out_last_next   = nib_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        out_nibble_reg <= out_nibble_next;
        out_rs_reg     <= out_rs_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_nibble          = out_nibble_reg;
    assign m_register_select = out_rs_reg;
    assign m_last            = out_last_reg;

endmodule
